// ===== hdl/jls_pkg.sv =====
`default_nettype none
package jls_pkg;

	localparam int DEF_MAX_SIZE  = 64;
	localparam int DEF_FRAC_BITS = 24;

	localparam int DATA_W  = 32;
	localparam int SIZE_W  = 7;
	localparam int ITER_W  = 16;
	localparam int TOL_W   = 31;
	localparam int RES_W   = 31;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 88;
	localparam int CFG_IW  = 2;

	localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 7'd64;
	localparam logic [ITER_W-1:0] MAX_ITER_RST    = 16'd10000;
	localparam logic [TOL_W-1:0]  TOLERANCE_RST   = 31'd16777;

	typedef enum logic [1:0] {
		MODE_WR_MATRIX = 2'd0,
		MODE_WR_RHS    = 2'd1,
		MODE_SOLVE     = 2'd2,
		MODE_READ      = 2'd3
	} mode_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_ACTIVE_SIZE = 2'd0,
		REG_MAX_ITER    = 2'd1,
		REG_TOLERANCE   = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

endpackage
`default_nettype wire

// ===== hdl/jacobi_linear_solver_unit.sv =====
// Jacobi solver over a matrix held in one synchronous RAM (MAX_SIZE^2 words), with the two x
// banks and the rhs vector in a second RAM. Matrix and rhs writes give no result. A read
// returns x[row] with the status of the last solve. A solve runs each row as a stream of
// multiply-accumulates, one column per cycle through the single read port of the matrix RAM,
// then a restoring divider at one quotient bit per cycle and a squared-change step, and the
// solve returns one result when it stops.
// The x banks are cleared logically at solve start, and rows beyond the size of the last
// solve read as zero, so there is no clearing pass.
`default_nettype none
module jacobi_linear_solver_unit
	import jls_pkg::*;
#(
	parameter int MAX_SIZE  = DEF_MAX_SIZE,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,   // mode[1:0], row[7:2], col[13:8], value[45:14]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,   // solution_value[31:0], iterations_done[47:32],
	                                          // converged[48], residual_sq[79:49],
	                                          // divide_fault[80]
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_SIZE + 1);
	localparam int CA_W  = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int XA_W  = $clog2(3 * MAX_SIZE);
	localparam int PRD_W = 2 * DATA_W;
	localparam int ACC_W = PRD_W - FRAC_BITS + $clog2(MAX_SIZE) + 1;
	localparam int NUM_W = ACC_W + 1;
	localparam int DVD_W = DATA_W + FRAC_BITS;
	localparam int DC_W  = $clog2(DVD_W + 1);
	localparam int MAG_W = DATA_W + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int RS_W  = SQ_W - FRAC_BITS + 1;
	localparam int LIM_W = 2 * TOL_W - FRAC_BITS;
	localparam int CMP_W = (LIM_W > RES_W) ? LIM_W : RES_W;

	localparam logic signed [NUM_W-1:0] NUM_HI = NUM_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [NUM_W-1:0] NUM_LO = NUM_W'(-64'sh0000_0000_8000_0000);
	localparam logic [DVD_W-1:0] Q_POS_MAX = DVD_W'(64'h7FFF_FFFF);
	localparam logic [DVD_W-1:0] Q_NEG_MAX = DVD_W'(64'h8000_0000);
	localparam logic [RS_W-1:0]  RS_MAX    = RS_W'(64'h7FFF_FFFF);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_INIT, S_SWEEP, S_ROW, S_DIVSET, S_DIV, S_XN,
		S_DIFF, S_SQ, S_RES, S_SWEND, S_DONE
	} state_t;

	state_t st_q;

	logic [SIZE_W-1:0] active_size_q;
	logic [ITER_W-1:0] max_iter_q;
	logic [TOL_W-1:0]  tol_q;

	logic [DATA_W-1:0] coeff_mem [MAX_SIZE*MAX_SIZE];
	logic [DATA_W-1:0] x_mem [3*MAX_SIZE];
	logic [DATA_W-1:0] coeff_rd_q, x_rd_q;

	logic [CNT_W-1:0] n_q, i_q, jn_q, j_s1;
	logic             cur_q, xzero_q, v_s1, v_s2;
	logic signed [PRD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [DATA_W-1:0] diag_q, xoi_q, xn_q;
	logic [DATA_W-1:0] rem_q, dvs_q;
	logic [DVD_W-1:0]  dvd_q, quo_q;
	logic [DC_W-1:0]   dcnt_q;
	logic              neg_q, row_ok_q;
	logic [MAG_W-1:0]  mag_q;
	logic [SQ_W-1:0]   sq_s;
	logic [RES_W-1:0]  res_q, last_res_q;
	logic [LIM_W-1:0]  limit_q;
	logic [ITER_W-1:0] iters_q, last_iter_q;
	logic              conv_q, fault_q, last_conv_q, last_fault_q;
	logic [DATA_W-1:0] sol_q;

	mode_t             in_mode;
	logic [5:0]        in_row, in_col;
	logic [DATA_W-1:0] in_value;
	logic              in_xfer;
	logic [CNT_W-1:0]  n_c;
	logic              cw_en, rw_en, xw_en;
	logic [CA_W-1:0]   cw_addr, cr_addr;
	logic [XA_W-1:0]   xr_addr, xw_addr;
	logic [DATA_W-1:0] xw_data;
	logic [DATA_W-1:0] xo_c;
	logic signed [NUM_W-1:0] num_w, num_c;
	logic [DATA_W-1:0] num_mag, diag_mag;
	logic [DATA_W:0]   rem_sh;
	logic              rem_ge;
	logic signed [MAG_W-1:0] d_c;
	logic [RS_W-1:0]   res_sum;

	assign in_mode  = mode_t'(s_tdata[1:0]);
	assign in_row   = s_tdata[7:2];
	assign in_col   = s_tdata[13:8];
	assign in_value = s_tdata[45:14];
	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (st_q == S_IDLE) && (!m_tvalid || m_tready);
	assign cfg_ready = 1'b1;

	always_comb begin
		if (active_size_q == '0)
			n_c = CNT_W'(1);
		else if (int'(active_size_q) > MAX_SIZE)
			n_c = CNT_W'(MAX_SIZE);
		else
			n_c = CNT_W'(active_size_q);
	end

	assign cw_en   = in_xfer && (in_mode == MODE_WR_MATRIX) && (int'(in_row) < MAX_SIZE)
		&& (int'(in_col) < MAX_SIZE);
	assign cw_addr = CA_W'(int'(in_row) * MAX_SIZE + int'(in_col));
	assign cr_addr = CA_W'(int'(i_q) * MAX_SIZE + int'(jn_q));
	assign rw_en   = in_xfer && (in_mode == MODE_WR_RHS) && (int'(in_row) < MAX_SIZE);
	assign xr_addr = (st_q == S_IDLE) ? XA_W'(int'(cur_q) * MAX_SIZE + int'(in_row))
		: ((st_q == S_ROW) && (jn_q == n_q)) ? XA_W'(2 * MAX_SIZE + int'(i_q))
		: XA_W'(int'(cur_q) * MAX_SIZE + int'(jn_q));
	assign xw_en   = (st_q == S_DIFF) || rw_en;
	assign xw_addr = (st_q == S_DIFF) ? XA_W'(int'(!cur_q) * MAX_SIZE + int'(i_q))
		: XA_W'(2 * MAX_SIZE + int'(in_row));
	assign xw_data = (st_q == S_DIFF) ? xn_q : in_value;

	always_ff @(posedge clk) begin
		if (cw_en)
			coeff_mem[cw_addr] <= in_value;
		coeff_rd_q <= coeff_mem[cr_addr];
	end

	// Writes go to the other bank from the one being read: no same-entry overlap.
	always_ff @(posedge clk) begin
		if (xw_en)
			x_mem[xw_addr] <= xw_data;
		x_rd_q <= x_mem[xr_addr];
	end

	assign xo_c = xzero_q ? '0 : x_rd_q;

	always_comb begin
		num_w = NUM_W'($signed(x_rd_q)) - NUM_W'(acc_q);
		if (num_w > NUM_HI)
			num_c = NUM_HI;
		else if (num_w < NUM_LO)
			num_c = NUM_LO;
		else
			num_c = num_w;
		num_mag  = num_c[NUM_W-1] ? DATA_W'(-num_c) : DATA_W'(num_c);
		diag_mag = diag_q[DATA_W-1] ? (~diag_q + 1'b1) : diag_q;
		rem_sh   = {rem_q, dvd_q[DVD_W-1]};
		rem_ge   = rem_sh >= {1'b0, dvs_q};
		d_c      = MAG_W'($signed(xn_q)) - MAG_W'($signed(xoi_q));
		res_sum  = RS_W'(res_q) + RS_W'(sq_s >> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RST;
			max_iter_q    <= MAX_ITER_RST;
			tol_q         <= TOLERANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTIVE_SIZE: active_size_q <= cfg_data[SIZE_W-1:0];
				REG_MAX_ITER:    max_iter_q    <= cfg_data[ITER_W-1:0];
				REG_TOLERANCE:   tol_q         <= cfg_data[TOL_W-1:0];
				REG_NONE:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			m_tvalid     <= 1'b0;
			cur_q        <= 1'b0;
			xzero_q      <= 1'b1;
			n_q          <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			last_iter_q  <= '0;
			last_res_q   <= '0;
			last_conv_q  <= 1'b0;
			last_fault_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						row_ok_q <= (CNT_W'(in_row) < n_c) && (CNT_W'(in_row) < n_q);
						if (in_mode == MODE_SOLVE)
							st_q <= S_INIT;
						else if (in_mode == MODE_READ)
							st_q <= S_READ;
					end
				end
				S_READ: begin
					sol_q    <= (row_ok_q && !xzero_q) ? x_rd_q : '0;
					m_tvalid <= 1'b1;
					st_q     <= S_IDLE;
				end
				S_INIT: begin
					n_q     <= n_c;
					limit_q <= LIM_W'((2*TOL_W)'(tol_q) * (2*TOL_W)'(tol_q) >> FRAC_BITS);
					cur_q   <= 1'b0;
					xzero_q <= 1'b1;
					iters_q <= '0;
					res_q   <= '0;
					conv_q  <= 1'b0;
					fault_q <= 1'b0;
					st_q    <= (max_iter_q == '0) ? S_DONE : S_SWEEP;
				end
				S_SWEEP: begin
					iters_q <= iters_q + 1'b1;
					res_q   <= '0;
					i_q     <= '0;
					jn_q    <= '0;
					acc_q   <= '0;
					v_s1    <= 1'b0;
					v_s2    <= 1'b0;
					st_q    <= S_ROW;
				end
				S_ROW: begin
					if (jn_q < n_q)
						jn_q <= jn_q + 1'b1;
					v_s1 <= jn_q < n_q;
					j_s1 <= jn_q;
					v_s2 <= v_s1 && (j_s1 != i_q);
					if (v_s1 && (j_s1 == i_q)) begin
						diag_q <= coeff_rd_q;
						xoi_q  <= xo_c;
					end
					prod_s2 <= $signed(coeff_rd_q) * $signed(xo_c);
					if (v_s2)
						acc_q <= acc_q + ACC_W'(prod_s2 >>> FRAC_BITS);
					if ((jn_q == n_q) && !v_s1 && !v_s2)
						st_q <= S_DIVSET;
				end
				S_DIVSET: begin
					rem_q  <= '0;
					dvd_q  <= DVD_W'(num_mag) << FRAC_BITS;
					dvs_q  <= diag_mag;
					quo_q  <= '0;
					dcnt_q <= '0;
					neg_q  <= num_c[NUM_W-1] ^ diag_q[DATA_W-1];
					if (diag_q == '0) begin
						fault_q <= 1'b1;
						xn_q    <= '0;
						st_q    <= S_DIFF;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= rem_ge ? DATA_W'(rem_sh - {1'b0, dvs_q}) : DATA_W'(rem_sh);
					quo_q  <= {quo_q[DVD_W-2:0], rem_ge};
					dvd_q  <= dvd_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DC_W'(DVD_W - 1))
						st_q <= S_XN;
				end
				S_XN: begin
					if (neg_q)
						xn_q <= (quo_q > Q_NEG_MAX) ? 32'h8000_0000 : DATA_W'(-quo_q);
					else
						xn_q <= (quo_q > Q_POS_MAX) ? 32'h7FFF_FFFF : DATA_W'(quo_q);
					st_q <= S_DIFF;
				end
				S_DIFF: begin
					mag_q <= d_c[MAG_W-1] ? MAG_W'(-d_c) : MAG_W'(d_c);
					st_q  <= S_SQ;
				end
				S_SQ: begin
					sq_s <= SQ_W'(mag_q) * SQ_W'(mag_q);
					st_q <= S_RES;
				end
				S_RES: begin
					res_q <= (res_sum > RS_MAX) ? RES_W'(RS_MAX) : RES_W'(res_sum);
					i_q   <= i_q + 1'b1;
					jn_q  <= '0;
					acc_q <= '0;
					st_q  <= (i_q + 1'b1 == n_q) ? S_SWEND : S_ROW;
				end
				S_SWEND: begin
					cur_q   <= !cur_q;
					xzero_q <= 1'b0;
					if (CMP_W'(res_q) <= CMP_W'(limit_q)) begin
						conv_q <= 1'b1;
						st_q   <= S_DONE;
					end else if (iters_q == max_iter_q) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_SWEEP;
					end
				end
				S_DONE: begin
					last_iter_q  <= iters_q;
					last_res_q   <= res_q;
					last_conv_q  <= conv_q;
					last_fault_q <= fault_q;
					sol_q        <= '0;
					m_tvalid     <= 1'b1;
					st_q         <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tdata = {7'd0, last_fault_q, last_res_q, last_conv_q, last_iter_q, sol_q};

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_tready)
		else $error("input taken while busy");

	a_solve_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (in_mode == MODE_SOLVE)) |=> (st_q == S_INIT))
		else $error("solve request not started");

	a_conv_limit: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == S_DONE) && conv_q) |-> (CMP_W'(res_q) <= CMP_W'(limit_q)))
		else $error("converged above limit");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ROW) |-> ((jn_q <= n_q) && (i_q < n_q)))
		else $error("row index past size");

endmodule
`default_nettype wire

// ===== test/jacobi_linear_solver_unit_chk.sv =====
`timescale 1ns / 1ps
module jacobi_linear_solver_unit_chk
	import jls_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [OUT_W-1:0]  m_tdata,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	output int                     errors,
	output int                     pending
);

	localparam int NMAX = DEF_MAX_SIZE;
	localparam int FB   = DEF_FRAC_BITS;

	typedef struct packed {
		logic        fault;
		logic [30:0] res;
		logic        conv;
		logic [15:0] iters;
		logic [31:0] sol;
	} status_t;

	logic signed [31:0] coeff [0:NMAX*NMAX-1];
	logic signed [31:0] rhs [0:NMAX-1];
	logic signed [31:0] xbank [0:1][0:NMAX-1];
	logic               cur;
	logic [15:0]        last_iters;
	logic [30:0]        last_res;
	logic               last_conv;
	logic               last_fault;
	logic [6:0]         size_reg;
	logic [15:0]        iter_reg;
	logic [30:0]        tol_reg;
	status_t            status_q [$];

	assign pending = status_q.size();

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic int rows_used();
		if (size_reg == 0) return 1;
		if (size_reg > NMAX) return NMAX;
		return size_reg;
	endfunction

	function automatic void run_sweeps();
		int n;
		longint unsigned lim;
		longint unsigned res;
		longint unsigned m;
		longint acc, num, diag, d;
		int iters;
		bit conv, fault;
		n = rows_used();
		lim = (longint'(tol_reg) * longint'(tol_reg)) >> FB;
		iters = 0;
		res = 0;
		conv = 0;
		fault = 0;
		for (int i = 0; i < NMAX; i++) begin
			xbank[0][i] = 0;
			xbank[1][i] = 0;
		end
		cur = 0;
		while (iters < iter_reg) begin
			iters++;
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					if (i != j)
						acc += (longint'(coeff[i*NMAX+j]) * longint'(xbank[cur][j])) >>> FB;
				num = clamp32(longint'(rhs[i]) - acc);
				diag = coeff[i*NMAX+i];
				if (diag == 0) begin
					fault = 1;
					xbank[!cur][i] = 0;
				end else begin
					xbank[!cur][i] = clamp32((num * (64'sd1 <<< FB)) / diag);
				end
			end
			res = 0;
			for (int i = 0; i < n; i++) begin
				d = longint'(xbank[!cur][i]) - longint'(xbank[cur][i]);
				m = (d < 0) ? -d : d;
				res += (m * m) >> FB;
				if (res > 64'd2147483647) res = 64'd2147483647;
			end
			cur = !cur;
			if (res <= lim) begin
				conv = 1;
				break;
			end
		end
		last_iters = iters[15:0];
		last_res = res[30:0];
		last_conv = conv;
		last_fault = fault;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t want, got;
		mode_t mode;
		logic [5:0] row, col;
		if (!arst_n) begin
			for (int i = 0; i < NMAX*NMAX; i++) coeff[i] = 0;
			for (int i = 0; i < NMAX; i++) begin
				rhs[i] = 0;
				xbank[0][i] = 0;
				xbank[1][i] = 0;
			end
			cur = 0;
			last_iters = 0;
			last_res = 0;
			last_conv = 0;
			last_fault = 0;
			size_reg = ACTIVE_SIZE_RST;
			iter_reg = MAX_ITER_RST;
			tol_reg = TOLERANCE_RST;
			errors = 0;
			status_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = status_t'(m_tdata[80:0]);
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, m_tdata);
				end else begin
					want = status_q.pop_front();
					if (got.sol !== want.sol) begin
						errors++;
						$display("%0t: solution_value exp %h got %h", $time, want.sol, got.sol);
					end
					if (got.iters !== want.iters) begin
						errors++;
						$display("%0t: iterations_done exp %0d got %0d", $time, want.iters,
							got.iters);
					end
					if (got.conv !== want.conv) begin
						errors++;
						$display("%0t: converged exp %b got %b", $time, want.conv, got.conv);
					end
					if (got.res !== want.res) begin
						errors++;
						$display("%0t: residual_sq exp %h got %h", $time, want.res, got.res);
					end
					if (got.fault !== want.fault) begin
						errors++;
						$display("%0t: divide_fault exp %b got %b", $time, want.fault,
							got.fault);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ACTIVE_SIZE: size_reg = cfg_data[6:0];
					REG_MAX_ITER:    iter_reg = cfg_data[15:0];
					REG_TOLERANCE:   tol_reg = cfg_data[30:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				mode = mode_t'(s_tdata[1:0]);
				row = s_tdata[7:2];
				col = s_tdata[13:8];
				case (mode)
					MODE_WR_MATRIX: coeff[row*NMAX+col] = s_tdata[45:14];
					MODE_WR_RHS:    rhs[row] = s_tdata[45:14];
					default: begin
						want.sol = 0;
						if (mode == MODE_SOLVE)
							run_sweeps();
						else if (row < rows_used())
							want.sol = xbank[cur][row];
						want.iters = last_iters;
						want.conv = last_conv;
						want.res = last_res;
						want.fault = last_fault;
						status_q.push_back(want);
					end
				endcase
			end
		end
	end

endmodule

// ===== test/jacobi_linear_solver_unit_tb.sv =====
`timescale 1ns / 1ps
module jacobi_linear_solver_unit_tb;
	import jls_pkg::*;

	localparam int ONE = 1 << DEF_FRAC_BITS;
	localparam int WATCH_LIMIT = 100000;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // mode[1:0], row[7:2], col[13:8], value[45:14]
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // solution_value[31:0], iterations_done[47:32],
	                              // converged[48], residual_sq[79:49], divide_fault[80]
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	int                errors;
	int                pending;
	int                quiet_cycles;
	int                rand_items;
	bit                stall_req;
	bit                calm_tx;
	bit                calm_rx;

	jacobi_linear_solver_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	jacobi_linear_solver_unit_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("jacobi_linear_solver_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		int hold;
		m_tready = 0;
		hold = 0;
		calm_rx = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0) calm_rx = !calm_rx;
			if (stall_req) begin
				m_tready = 0;
				repeat (400) @(negedge clk);
				stall_req = 0;
			end else if (calm_rx) begin
				m_tready = 1;
			end else if (hold > 0) begin
				m_tready = 0;
				hold--;
			end else if ($urandom_range(0, 5) == 0) begin
				m_tready = 0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
					$urandom_range(0, 2);
			end else begin
				m_tready = 1;
			end
		end
	end

	task automatic send_item(mode_t mode, int row, int col, logic [31:0] value);
		int gap;
		if ($urandom_range(0, 299) == 0) calm_tx = !calm_tx;
		if (!calm_tx && $urandom_range(0, 4) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
				$urandom_range(1, 3);
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {2'b00, value, col[5:0], row[5:0], mode};
		do @(posedge clk); while (!s_tready);
		rand_items++;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		s_tvalid = 0;
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] coeff_val(int style, bit on_diag);
		if (style == 1) return $urandom;
		if (on_diag) begin
			if ($urandom_range(0, 19) == 0) return 0;
			return $urandom_range(2, 4) * ONE + $urandom_range(0, ONE / 2);
		end
		return $urandom_range(0, ONE) - ONE / 2;
	endfunction

	task automatic load_system(int n, int style);
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++)
				send_item(MODE_WR_MATRIX, r, c, coeff_val(style, r == c));
			send_item(MODE_WR_RHS, r, 0,
				(style == 1) ? $urandom : $urandom_range(0, 8 * ONE) - 4 * ONE);
		end
	endtask

	initial begin
		int n, style, ops, r, c, pick;
		bit stalled;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_ACTIVE_SIZE;
		cfg_data = '0;
		stall_req = 0;
		stalled = 0;
		calm_tx = 0;
		rand_items = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		write_reg(REG_ACTIVE_SIZE, 2);
		write_reg(REG_MAX_ITER, 6);
		write_reg(REG_TOLERANCE, TOLERANCE_RST);
		send_item(MODE_READ, 0, 0, 0);
		send_item(MODE_WR_MATRIX, 0, 0, 4 * ONE);
		send_item(MODE_WR_MATRIX, 0, 1, ONE);
		send_item(MODE_WR_MATRIX, 1, 0, ONE);
		send_item(MODE_WR_MATRIX, 1, 1, 3 * ONE);
		send_item(MODE_WR_RHS, 0, 0, ONE);
		send_item(MODE_WR_RHS, 1, 0, 2 * ONE);
		send_item(MODE_SOLVE, 0, 0, 0);
		send_item(MODE_READ, 0, 0, 0);
		send_item(MODE_READ, 1, 0, 0);
		send_item(MODE_READ, 63, 63, 32'hFFFF_FFFF);
		send_item(MODE_WR_RHS, 0, 0, 32'h7FFF_FFFF);
		send_item(MODE_WR_RHS, 1, 0, 32'h8000_0000);
		send_item(MODE_WR_MATRIX, 0, 1, 32'h8000_0000);
		send_item(MODE_WR_MATRIX, 0, 0, 1);
		send_item(MODE_SOLVE, 0, 0, 0);
		send_item(MODE_READ, 0, 0, 0);
		send_item(MODE_WR_MATRIX, 1, 1, 0);
		send_item(MODE_SOLVE, 0, 0, 0);
		send_item(MODE_READ, 1, 0, 0);
		drain();
		write_reg(REG_MAX_ITER, 0);
		send_item(MODE_SOLVE, 0, 0, 0);
		send_item(MODE_READ, 0, 0, 0);
		drain();
		write_reg(REG_ACTIVE_SIZE, 0);
		write_reg(REG_MAX_ITER, 65535);
		write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
		send_item(MODE_SOLVE, 0, 0, 0);
		send_item(MODE_READ, 0, 0, 0);
		send_item(MODE_READ, 1, 0, 0);
		drain();

		write_reg(REG_ACTIVE_SIZE, 100);
		send_item(MODE_READ, 63, 0, 0);
		send_item(MODE_READ, 1, 0, 0);
		drain();
		write_reg(REG_ACTIVE_SIZE, 64);
		send_item(MODE_READ, 63, 0, 0);
		send_item(MODE_READ, 0, 0, 0);
		drain();

		while (rand_items < 550) begin
			pick = $urandom_range(0, 9);
			n = (pick == 0) ? 0 : $urandom_range(1, 4);
			write_reg(REG_ACTIVE_SIZE, n);
			if (n == 0) n = 1;
			if (pick == 1) begin
				write_reg(REG_MAX_ITER, 65535);
				write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
			end else begin
				write_reg(REG_MAX_ITER, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
				case ($urandom_range(0, 3))
					0: write_reg(REG_TOLERANCE, 0);
					1: write_reg(REG_TOLERANCE, $urandom_range(1, 1 << 20));
					2: write_reg(REG_TOLERANCE, $urandom);
					default: write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
				endcase
			end
			style = ($urandom_range(0, 4) == 0) ? 1 : 0;
			load_system(n, style);
			if ((!stalled || $urandom_range(0, 5) == 0) && !stall_req) begin
				s_tvalid = 0;
				@(negedge clk);
				stall_req = 1;
				stalled = 1;
				repeat (12)
					send_item(MODE_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
			end
			ops = $urandom_range(15, 40);
			repeat (ops) begin
				pick = $urandom_range(0, 99);
				r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
				c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
				if (pick < 30)
					send_item(MODE_WR_MATRIX, r, c,
						($urandom_range(0, 4) == 0) ? $urandom : coeff_val(0, r == c));
				else if (pick < 45)
					send_item(MODE_WR_RHS, r, c,
						($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 4 * ONE));
				else if (pick < 60)
					send_item(MODE_SOLVE, r, c, $urandom);
				else
					send_item(MODE_READ, r, c, $urandom);
			end
			drain();
		end

		drain();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("jacobi_linear_solver_unit_tb: clean");
		else
			$display("jacobi_linear_solver_unit_tb: errors");
		$finish;
	end

endmodule
